[src/dto_pkg.sv]
// dto_pkg: shared constants and types for the dependency ordering block
// fixed field widths of the stream ports and the walk status bundle
// no dependencies
package dto_pkg;

	localparam int NODE_W     = 4;
	localparam int NCOUNT_W   = 5;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 8;
	localparam int M_TUSER_W  = 2;

	// status of the walk sequencer as seen by the load side
	typedef struct packed {
		logic busy;
		logic done;
		logic drop_hit;
	} walk_stat_t;

endpackage

[src/dto_ram.sv]
// dto_ram: generic single-write, single-read memory with registered read data
// used for the edge table, the per-node counts and the walk stack
// no dependencies
module dto_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/dto_walk.sv]
// dto_walk: depth-first walk sequencer with the stack in a memory
// holds the marks, the last-result hold register and the output register
// depends on dto_pkg and dto_ram
module dto_walk #(
	parameter int MAX_NODES = 16,
	parameter int MAX_DEPS  = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [$clog2(MAX_NODES+1)-1:0]       n,
	input  logic                                 drop_flag,
	output logic                                 rd_en,
	output logic [$clog2(MAX_NODES)-1:0]         rd_node,
	output logic [$clog2(MAX_DEPS+1)-1:0]        rd_child,
	input  logic [$clog2(MAX_DEPS+1)-1:0]        rd_count,
	input  logic [$clog2(MAX_NODES)-1:0]         rd_dep,
	output dto_pkg::walk_stat_t                  stat,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [dto_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	output logic                                 m_axis_tlast,
	output logic [dto_pkg::M_TUSER_W-1:0]        m_axis_tuser
);
	import dto_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int CW = $clog2(MAX_DEPS + 1);
	localparam int SEW = IW + CW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROOT  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_POP   = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0]           state_q, state_d;
	logic [NW-1:0]        root_q, root_d;
	logic [IW-1:0]        top_node_q, top_node_d;
	logic [CW-1:0]        top_child_q, top_child_d;
	logic [NW-1:0]        sp_q, sp_d;
	logic [MAX_NODES-1:0] visited_q, visited_d;
	logic [MAX_NODES-1:0] onstk_q, onstk_d;
	logic                 cyc_q, cyc_d;
	logic                 pend_vld_q, pend_vld_d;
	logic                 out_vld_q;

	logic [IW-1:0]        pend_node_q;
	logic                 pend_drop_q;
	logic                 pend_cyc_q;
	logic [IW-1:0]        out_node_q;
	logic                 out_last_q;
	logic                 out_drop_q;
	logic                 out_cyc_q;

	logic                 pend_load;
	logic                 out_load;
	logic                 out_last_d;
	logic                 out_free;
	logic                 drop_hit;
	logic                 done;

	logic                 stk_we;
	logic [IW-1:0]        stk_waddr;
	logic [SEW-1:0]       stk_wdata;
	logic                 stk_re;
	logic [IW-1:0]        stk_raddr;
	logic [SEW-1:0]       stk_rdata;

	// stack entries below the top; the top itself lives in top_node_q/top_child_q
	dto_ram #(
		.WIDTH(SEW),
		.DEPTH(MAX_NODES)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	assign out_free = !out_vld_q || m_axis_tready;

	always_comb begin
		state_d     = state_q;
		root_d      = root_q;
		top_node_d  = top_node_q;
		top_child_d = top_child_q;
		sp_d        = sp_q;
		visited_d   = visited_q;
		onstk_d     = onstk_q;
		cyc_d       = cyc_q;
		pend_vld_d  = pend_vld_q;
		pend_load   = 1'b0;
		out_load    = 1'b0;
		out_last_d  = 1'b0;
		rd_en       = 1'b0;
		drop_hit    = 1'b0;
		done        = 1'b0;
		stk_we      = 1'b0;
		stk_waddr   = IW'(sp_q - NW'(1));
		stk_wdata   = {top_node_q, CW'(top_child_q + CW'(1))};
		stk_re      = 1'b0;
		stk_raddr   = IW'(sp_q - NW'(2));
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					root_d  = '0;
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_q >= n) begin
					state_d = ST_FLUSH;
				end else if (visited_q[root_q[IW-1:0]]) begin
					root_d = NW'(root_q + NW'(1));
				end else begin
					top_node_d                = root_q[IW-1:0];
					top_child_d               = '0;
					onstk_d[root_q[IW-1:0]]   = 1'b1;
					sp_d                      = NW'(1);
					state_d                   = ST_FETCH;
				end
			end
			ST_FETCH: begin
				rd_en   = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (top_child_q < rd_count) begin
					top_child_d = CW'(top_child_q + CW'(1));
					state_d     = ST_FETCH;
					if (NW'(rd_dep) >= n) begin
						drop_hit = 1'b1;
					end else if (visited_q[rd_dep]) begin
						// already placed, nothing to do
						state_d = ST_FETCH;
					end else if (onstk_q[rd_dep] || sp_q == NW'(MAX_NODES)) begin
						cyc_d = 1'b1;
					end else begin
						stk_we          = 1'b1;
						top_node_d      = rd_dep;
						top_child_d     = '0;
						onstk_d[rd_dep] = 1'b1;
						sp_d            = NW'(sp_q + NW'(1));
					end
				end else if (!pend_vld_q || out_free) begin
					// node finished: hold it back one result so the final one can carry tlast
					visited_d[top_node_q] = 1'b1;
					onstk_d[top_node_q]   = 1'b0;
					pend_load             = 1'b1;
					pend_vld_d            = 1'b1;
					out_load              = pend_vld_q;
					sp_d                  = NW'(sp_q - NW'(1));
					if (sp_q == NW'(1)) begin
						root_d  = NW'(root_q + NW'(1));
						state_d = ST_ROOT;
					end else begin
						stk_re  = 1'b1;
						state_d = ST_POP;
					end
				end
			end
			ST_POP: begin
				top_node_d  = stk_rdata[SEW-1:CW];
				top_child_d = stk_rdata[CW-1:0];
				state_d     = ST_FETCH;
			end
			ST_FLUSH: begin
				if (!pend_vld_q || out_free) begin
					out_load   = pend_vld_q;
					out_last_d = 1'b1;
					pend_vld_d = 1'b0;
					done       = 1'b1;
					visited_d  = '0;
					onstk_d    = '0;
					cyc_d      = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			root_q      <= '0;
			top_node_q  <= '0;
			top_child_q <= '0;
			sp_q        <= '0;
			visited_q   <= '0;
			onstk_q     <= '0;
			cyc_q       <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			root_q      <= root_d;
			top_node_q  <= top_node_d;
			top_child_q <= top_child_d;
			sp_q        <= sp_d;
			visited_q   <= visited_d;
			onstk_q     <= onstk_d;
			cyc_q       <= cyc_d;
			pend_vld_q  <= pend_vld_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_node_q <= top_node_q;
			pend_drop_q <= drop_flag;
			pend_cyc_q  <= cyc_q;
		end
		if (out_load) begin
			out_node_q <= pend_node_q;
			out_last_q <= out_last_d;
			out_drop_q <= pend_drop_q;
			out_cyc_q  <= pend_cyc_q;
		end
	end

	assign rd_node  = top_node_q;
	assign rd_child = top_child_q;

	assign stat.busy     = (state_q != ST_IDLE);
	assign stat.done     = done;
	assign stat.drop_hit = drop_hit;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(M_TDATA_W - NODE_W)'(0), NODE_W'(out_node_q)};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_cyc_q, out_drop_q};

endmodule

[src/dependency_topological_order.sv]
// Dependency ordering block. Edge transactions arrive one per cycle while input is not held
// off: node_index depends on dep_index, and each node keeps up to MAX_DEPS dependencies in a
// table memory, with a small count memory in front of it. Edges that name a node at or above
// node_count, or that overflow a node's list, are dropped and flagged. The transaction with
// tlast set closes the load: after its edge is stored the block stops taking input and walks
// the graph depth first from node 0 upward, giving every node 0 .. node_count-1 once on the
// output stream after all of its dependencies. A dependency on a node still being walked is a
// cycle: it is skipped and flagged. The final node of the order carries tlast, and its tuser
// holds the complete flags for the run. Afterwards counts, marks and flags are cleared and
// loading resumes. Load rate is one transaction per cycle while the walk is not busy. After
// the closing transaction input is held off while the walk visits the N nodes, the E stored
// edges of those nodes and the R walk roots (nodes not reached from a lower-numbered one),
// each edge visit going through registered reads of the count and table memories, and while
// the output side stalls. Write node_count only while the block is idle.
module dependency_topological_order #(
	parameter int MAX_NODES = 16,
	parameter int MAX_DEPS  = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: node_count
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dto_pkg::NCOUNT_W-1:0]    cfg_data,
	// edge input
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [dto_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [3:0] node_index, [7:4] dep_index
	input  logic                            s_axis_tlast,   // start_run
	input  logic                            s_axis_tuser,   // edge_valid
	// ordered output
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [dto_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [3:0] ordered_node, [7:4] zero
	output logic                            m_axis_tlast,   // last_of_run
	output logic [dto_pkg::M_TUSER_W-1:0]   m_axis_tuser    // [0] edge_dropped, [1] cycle_seen
);
	import dto_pkg::*;

	localparam int IW  = $clog2(MAX_NODES);
	localparam int NW  = $clog2(MAX_NODES + 1);
	localparam int CW  = $clog2(MAX_DEPS + 1);
	localparam int TD  = MAX_NODES * MAX_DEPS;
	localparam int TAW = $clog2(TD);
	localparam int XW  = (NW > NODE_W) ? NW : NODE_W;
	localparam int LW  = 7;

	logic [NCOUNT_W-1:0]  node_count_q;
	logic [NW-1:0]        n;

	logic                 vld_s1;
	logic [NODE_W-1:0]    node_s1;
	logic [NODE_W-1:0]    dep_s1;
	logic                 ev_s1;
	logic                 start_s1;

	logic                 fwd_vld_q;
	logic [IW-1:0]        fwd_node_q;
	logic [CW-1:0]        fwd_cnt_q;
	logic [MAX_NODES-1:0] cvld_q;
	logic                 drop_q;

	logic                 accept;
	logic [IW-1:0]        idx_s1;
	logic [CW-1:0]        cnt_eff;
	logic [CW-1:0]        cnt_next;
	logic                 node_ok;
	logic                 dep_ok;
	logic                 store;
	logic                 drop_s1;

	logic                 cnt_re;
	logic [IW-1:0]        cnt_raddr;
	logic [CW-1:0]        cnt_rdata;
	logic [TAW-1:0]       tbl_waddr;
	logic [TAW-1:0]       tbl_raddr;
	logic [IW-1:0]        tbl_rdata;

	logic                 w_rd_en;
	logic [IW-1:0]        w_rd_node;
	logic [CW-1:0]        w_rd_child;
	logic [CW-1:0]        w_rd_count;
	walk_stat_t           w_stat;

	// node_count above MAX_NODES acts as MAX_NODES
	assign n = ({(LW - NCOUNT_W)'(0), node_count_q} > LW'(MAX_NODES)) ?
		NW'(MAX_NODES) : NW'(node_count_q);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !w_stat.busy && !(vld_s1 && start_s1);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// load stage: count read was issued at accept, resolve and write back here
	assign idx_s1   = IW'(node_s1);
	assign node_ok  = XW'(node_s1) < XW'(n);
	assign dep_ok   = XW'(dep_s1) < XW'(n);
	assign cnt_eff  = (fwd_vld_q && fwd_node_q == idx_s1) ? fwd_cnt_q :
		(cvld_q[idx_s1] ? cnt_rdata : '0);
	assign cnt_next = CW'(cnt_eff + CW'(1));
	assign store    = vld_s1 && ev_s1 && node_ok && dep_ok && (cnt_eff < CW'(MAX_DEPS));
	assign drop_s1  = vld_s1 && ev_s1 && !store;

	assign tbl_waddr = TAW'(TAW'(idx_s1) * TAW'(MAX_DEPS) + TAW'(cnt_eff));
	assign tbl_raddr = TAW'(TAW'(w_rd_node) * TAW'(MAX_DEPS) + TAW'(w_rd_child));

	assign cnt_re    = w_stat.busy ? w_rd_en : accept;
	assign cnt_raddr = w_stat.busy ? w_rd_node : IW'(s_axis_tdata[NODE_W-1:0]);

	assign w_rd_count = cvld_q[w_rd_node] ? cnt_rdata : '0;

	dto_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_NODES)
	) u_counts (
		.clk  (clk),
		.we   (store),
		.waddr(idx_s1),
		.wdata(cnt_next),
		.re   (cnt_re),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	dto_ram #(
		.WIDTH(IW),
		.DEPTH(TD)
	) u_table (
		.clk  (clk),
		.we   (store),
		.waddr(tbl_waddr),
		.wdata(IW'(dep_s1)),
		.re   (w_rd_en),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	dto_walk #(
		.MAX_NODES(MAX_NODES),
		.MAX_DEPS (MAX_DEPS)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (vld_s1 && start_s1),
		.n            (n),
		.drop_flag    (drop_q),
		.rd_en        (w_rd_en),
		.rd_node      (w_rd_node),
		.rd_child     (w_rd_child),
		.rd_count     (w_rd_count),
		.rd_dep       (tbl_rdata),
		.stat         (w_stat),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			vld_s1       <= 1'b0;
			fwd_vld_q    <= 1'b0;
			cvld_q       <= '0;
			drop_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			vld_s1    <= accept;
			fwd_vld_q <= store;
			if (w_stat.done) begin
				cvld_q <= '0;
				drop_q <= 1'b0;
			end else begin
				if (store) begin
					cvld_q[idx_s1] <= 1'b1;
				end
				drop_q <= drop_q | drop_s1 | w_stat.drop_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			node_s1  <= s_axis_tdata[NODE_W-1:0];
			dep_s1   <= s_axis_tdata[2*NODE_W-1:NODE_W];
			ev_s1    <= s_axis_tuser;
			start_s1 <= s_axis_tlast;
		end
		if (store) begin
			fwd_node_q <= idx_s1;
			fwd_cnt_q  <= cnt_next;
		end
	end

endmodule
